>>> rtl/rart_pkg.sv
// ---------------------------------------------------------------------------
// Rotor angle and rate tracker: shared package
// Field widths, encoder constants and the control group that steps the
// rate averaging divider.
// ---------------------------------------------------------------------------
`default_nettype none

package rart_pkg;

  // Field widths.
  localparam int POS_W  = 13;
  localparam int RATE_W = 14;
  localparam int EXT_W  = 15;
  localparam int ANG_W  = 13;
  localparam int RAD_W  = 16;

  // Default depth of the rate history.
  localparam int RATE_SAMPLES_DEF = 8;

  // Encoder constants.
  localparam logic [POS_W-1:0] HALF_TURN        = 13'd4096;
  localparam logic signed [EXT_W-1:0] TURN_CNT  = 15'sd8192;
  localparam logic signed [EXT_W-1:0] WRAP_LIM  = 15'sd7500;
  // 2*pi in Q16, rounded.
  localparam logic [19:0] TWO_PI_Q16            = 20'd411775;

  typedef logic signed [RATE_W-1:0] rate_t;

  // Stage loads handed to the divider.
  typedef struct packed {
    logic ld_s3;
    logic ld_out;
  } div_ctl_t;

endpackage

`default_nettype wire

>>> rtl/rotor_angle_rate_tracker_core.sv
// ---------------------------------------------------------------------------
// Rotor angle and rate tracker
// Unwraps 13-bit encoder samples into a turn-extended position and a rate,
// averages the rate over a row of history cells, and reports the angle
// from a programmable zero offset in counts and in Q13 radians.
// ---------------------------------------------------------------------------
//
// Channel  | Direction | Ports                      | Contents
// ---------+-----------+----------------------------+-------------------------
// in       | slave     | in_tvalid/tready/tdata     | raw_position
// out      | master    | out_tvalid/tready/tdata    | position, rates, angle
// cfg      | write     | cfg_wen/cfg_wdata          | zero_offset
//
// One sample is taken every cycle unless a stalled output backs up the stages.
// Four register stages (unwrap, sum and angle product, reciprocal multiply and
// rounding, output) carry each result to the bus in that order. A stage loads
// when the next one is empty or moving, so bubbles close up and a stalled
// output still lets earlier stages fill.
// Synchronous reset clears the valids, history, sum, unwrap state and offset.
// ---------------------------------------------------------------------------
`default_nettype none

module rotor_angle_rate_tracker_core #(
  parameter int RATE_SAMPLES = rart_pkg::RATE_SAMPLES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Input samples.
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [15:0]                  in_tdata,   // [12:0] raw_position, [15:13] zero
  // Results.
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // [14:0] extended_position, [28:15] raw_rate, [42:29] filtered_rate,
  // [55:43] angle_counts, [71:56] angle_radians
  output logic [71:0]                  out_tdata,
  // Zero offset register.
  input  wire                          cfg_wen,
  input  wire  [rart_pkg::POS_W-1:0]   cfg_wdata
);
  import rart_pkg::*;

  localparam int SUM_W = RATE_W + $clog2(RATE_SAMPLES);

  // Configuration and unwrap state.
  logic [POS_W-1:0] zero_offset_r;
  logic [POS_W-1:0] prev_r;
  logic             started_r;

  // Stage valids and loads.
  logic v1_r, v2_r, v3_r, vout_r;
  logic ld1, ld2, ld3, ld_out;
  logic accept;
  div_ctl_t div_ctl;

  // Stage one, combinational unwrap.
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        prev_eff;
  logic signed [EXT_W-1:0] diff_c;
  logic signed [EXT_W-1:0] rate_wide_c;
  logic signed [1:0]       turn_c;
  logic signed [EXT_W-1:0] ext_c;
  rate_t                   rate_c;
  logic [ANG_W-1:0]        counts_c;

  // Stage registers.
  rate_t                   rate_s1_r, rate_s2_r, rate_s3_r, rate_o_r;
  rate_t                   oldest_s1_r;
  logic signed [EXT_W-1:0] ext_s1_r, ext_s2_r, ext_s3_r, ext_o_r;
  logic signed [ANG_W-1:0] counts_s1_r, counts_s2_r, counts_s3_r, counts_o_r;
  logic signed [32:0]      prod_c, prod_s2_r;
  logic [32:0]             prod_mag_c;
  logic [32:0]             prod_rnd_c;
  logic signed [RAD_W-1:0] rad_mag_c;
  logic signed [RAD_W-1:0] rad_s3_r, rad_o_r;

  // Running sum of the history.
  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_s2_r;
  rate_t                   filt;

  // History cells.
  rate_t cell_d [RATE_SAMPLES];
  rate_t cell_q [RATE_SAMPLES];

  // ------------------------------------------------------------------------
  // Flow control
  // ------------------------------------------------------------------------
  assign ld_out    = !vout_r || out_tready;
  assign ld3       = !v3_r || ld_out;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;
  assign accept    = in_tvalid && ld1;

  assign div_ctl.ld_s3  = ld3;
  assign div_ctl.ld_out = ld_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      if (ld1)    v1_r   <= in_tvalid;
      if (ld2)    v2_r   <= v1_r;
      if (ld3)    v3_r   <= v2_r;
      if (ld_out) vout_r <= v3_r;
    end
  end

  // ------------------------------------------------------------------------
  // Configuration and unwrap state
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r <= '0;
      prev_r        <= '0;
      started_r     <= 1'b0;
    end else begin
      if (cfg_wen) zero_offset_r <= cfg_wdata;
      if (accept) begin
        prev_r    <= pos;
        started_r <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stage one: unwrap the sample against the previous one. On the first
  // sample the previous position is the sample itself, so the rate is zero
  // and the turn comes from where the sample sits relative to the offset.
  // ------------------------------------------------------------------------
  always_comb begin
    pos      = in_tdata[POS_W-1:0];
    prev_eff = started_r ? prev_r : pos;
    diff_c   = $signed({2'b00, pos}) - $signed({2'b00, prev_eff});
    turn_c   = 2'sd0;
    if (!started_r) begin
      if (zero_offset_r >= HALF_TURN) begin
        if (pos < zero_offset_r - HALF_TURN) turn_c = 2'sd1;
      end else begin
        if (pos > zero_offset_r + HALF_TURN) turn_c = -2'sd1;
      end
    end
    rate_wide_c = diff_c;
    if (diff_c < -WRAP_LIM) begin
      turn_c      = 2'sd1;
      rate_wide_c = diff_c + TURN_CNT;
    end else if (diff_c > WRAP_LIM) begin
      turn_c      = -2'sd1;
      rate_wide_c = diff_c - TURN_CNT;
    end
    rate_c = rate_wide_c[RATE_W-1:0];
    case (turn_c)
      2'sd1:   ext_c = $signed({2'b00, pos}) + TURN_CNT;
      -2'sd1:  ext_c = $signed({2'b00, pos}) - TURN_CNT;
      default: ext_c = $signed({2'b00, pos});
    endcase
    // The wrap to a signed half turn either side is the 13-bit difference.
    counts_c = pos - zero_offset_r;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      rate_s1_r   <= rate_c;
      ext_s1_r    <= ext_c;
      counts_s1_r <= $signed(counts_c);
      oldest_s1_r <= cell_q[RATE_SAMPLES-1];
    end
  end

  // ------------------------------------------------------------------------
  // History: a row of cells that shifts once per accepted sample. The value
  // leaving the last cell is the one the running sum drops.
  // ------------------------------------------------------------------------
  assign cell_d[0] = rate_c;

  for (genvar g = 0; g < RATE_SAMPLES; g++) begin : g_cell
    if (g > 0) begin : g_link
      assign cell_d[g] = cell_q[g-1];
    end
    rart_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .d_in     (cell_d[g]),
      .q        (cell_q[g])
    );
  end

  // ------------------------------------------------------------------------
  // Stage two: running sum update and the angle to radians product.
  // ------------------------------------------------------------------------
  always_comb begin
    sum_nxt = sum_r + SUM_W'(rate_s1_r) - SUM_W'(oldest_s1_r);
    prod_c  = $signed({{20{counts_s1_r[ANG_W-1]}}, counts_s1_r})
            * $signed({13'b0, TWO_PI_Q16});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (v1_r && ld2) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      sum_s2_r    <= sum_nxt;
      rate_s2_r   <= rate_s1_r;
      ext_s2_r    <= ext_s1_r;
      counts_s2_r <= counts_s1_r;
      prod_s2_r   <= prod_c;
    end
  end

  // ------------------------------------------------------------------------
  // Stage three: round the product to Q13, half away from zero.
  // ------------------------------------------------------------------------
  always_comb begin
    prod_mag_c = prod_s2_r[32] ? (~prod_s2_r + 1'b1) : prod_s2_r;
    prod_rnd_c = prod_mag_c + 33'd32768;
    rad_mag_c  = $signed(prod_rnd_c[31:16]);
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      rate_s3_r   <= rate_s2_r;
      ext_s3_r    <= ext_s2_r;
      counts_s3_r <= counts_s2_r;
      rad_s3_r    <= prod_s2_r[32] ? -rad_mag_c : rad_mag_c;
    end
  end

  // The divider spans stage three and the output register.
  rart_div #(
    .RATE_SAMPLES (RATE_SAMPLES)
  ) u_div (
    .clk    (clk),
    .ctl    (div_ctl),
    .sum_in (sum_s2_r),
    .filt   (filt)
  );

  // ------------------------------------------------------------------------
  // Output register.
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld_out) begin
      rate_o_r   <= rate_s3_r;
      ext_o_r    <= ext_s3_r;
      counts_o_r <= counts_s3_r;
      rad_o_r    <= rad_s3_r;
    end
  end

  assign out_tvalid = vout_r;
  assign out_tdata  = {rad_o_r, counts_o_r, filt, rate_o_r, ext_o_r};

endmodule

`default_nettype wire

>>> rtl/rart_cell.sv
// ---------------------------------------------------------------------------
// Rotor angle and rate tracker: rate history cell
// One slot of the rate history. On each accepted sample the cell takes the
// value of its upstream neighbor and passes its own value downstream.
// ---------------------------------------------------------------------------
`default_nettype none

module rart_cell (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               shift_en,
  input  rart_pkg::rate_t   d_in,
  output rart_pkg::rate_t   q
);
  import rart_pkg::*;

  rate_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

>>> rtl/rart_div.sv
// ---------------------------------------------------------------------------
// Rotor angle and rate tracker: average divider
// Divides the running rate sum by the history depth, truncating toward
// zero, through a reciprocal multiply in two register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module rart_div #(
  parameter int RATE_SAMPLES = rart_pkg::RATE_SAMPLES_DEF
) (
  input  wire                                                     clk,
  input  rart_pkg::div_ctl_t                                      ctl,
  input  wire signed [rart_pkg::RATE_W+$clog2(RATE_SAMPLES)-1:0] sum_in,
  output rart_pkg::rate_t                                         filt
);
  import rart_pkg::*;

  localparam int SUM_W = RATE_W + $clog2(RATE_SAMPLES);
  // The magnitude of the sum stays below 8192 * depth.
  localparam int MAG_W = SUM_W - 1;
  // Depth must be at most 64, which the block does not enforce; then a shift of MAG_W + 6 keeps the quotient exact.
  localparam int K     = MAG_W + 6;
  localparam longint unsigned RECIP =
    ((64'd1 << K) + longint'(RATE_SAMPLES) - 64'd1) / longint'(RATE_SAMPLES);
  localparam int PROD_W = MAG_W + K + 1;

  logic [K:0]         recip;
  logic [SUM_W-1:0]   abs_c;
  logic [MAG_W-1:0]   mag_c;
  logic [PROD_W-1:0]  qprod_s3_r;
  logic               neg_s3_r;
  rate_t              quot_c;
  rate_t              filt_r;

  assign recip = RECIP[K:0];

  always_comb begin
    abs_c  = sum_in[SUM_W-1] ? (~sum_in + 1'b1) : sum_in;
    mag_c  = abs_c[MAG_W-1:0];
    quot_c = qprod_s3_r[K +: RATE_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s3) begin
      qprod_s3_r <= PROD_W'(mag_c) * PROD_W'(recip);
      neg_s3_r   <= sum_in[SUM_W-1];
    end
    if (ctl.ld_out) begin
      filt_r <= neg_s3_r ? -quot_c : quot_c;
    end
  end

  assign filt = filt_r;

endmodule

`default_nettype wire
